// ===== rtl/adll_pkg.sv =====
// Package of shared constants, types and helper functions for the linked list engine.
`default_nettype none
package adll_pkg;

  localparam int SLOTS       = 64;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = $clog2(SLOTS);

  localparam int FIELD_IDX_W = 6;
  localparam int FIELD_VAL_W = 32;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 40;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 72;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [VALUE_BITS-1:0]  val_t;
  typedef logic [FIELD_IDX_W-1:0] fidx_t;
  typedef logic [FIELD_VAL_W-1:0] fval_t;
  typedef logic [MODE_W-1:0]      mode_t;
  typedef logic [STATUS_W-1:0]    status_t;

  localparam mode_t MODE_PUSH   = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_ERASE  = 2'd2;
  localparam mode_t MODE_READ   = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FREE     = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_SENTINEL = 2'd3;

  typedef logic [3:0] step_t;
  localparam step_t STEP_NONE      = 4'd0;
  localparam step_t STEP_CLEAR     = 4'd1;
  localparam step_t STEP_TAKE      = 4'd2;
  localparam step_t STEP_PB_NODE   = 4'd3;
  localparam step_t STEP_PB_LINK   = 4'd4;
  localparam step_t STEP_IA_NODE   = 4'd5;
  localparam step_t STEP_IA_LINK   = 4'd6;
  localparam step_t STEP_ER_UNLINK = 4'd7;
  localparam step_t STEP_ER_FREE   = 4'd8;

  typedef struct packed {
    logic    cap;
    logic    rd_free;
    step_t   step;
    logic    status_we;
    status_t status_code;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_valid;
    logic idx_zero;
    logic node_used;
    logic free_empty;
    logic clear_last;
  } dp_stat_t;

  typedef struct packed {
    fidx_t   tail_index;
    fidx_t   head_index;
    logic    node_used;
    fidx_t   node_prev;
    fidx_t   node_next;
    fval_t   node_value;
    fidx_t   slot;
    status_t status;
  } res_t;

  localparam int RES_W     = $bits(res_t);
  localparam int OUT_PAD_W = OUT_DATA_W - RES_W;

  function automatic idx_t idx_of(fidx_t raw);
    logic [IDX_W+FIELD_IDX_W-1:0] t;
    t = (IDX_W+FIELD_IDX_W)'(raw);
    return t[IDX_W-1:0];
  endfunction

  function automatic fidx_t idx_to_field(idx_t x);
    logic [IDX_W+FIELD_IDX_W-1:0] t;
    t = (IDX_W+FIELD_IDX_W)'(x);
    return t[FIELD_IDX_W-1:0];
  endfunction

  function automatic val_t val_of(fval_t v);
    logic [VALUE_BITS+FIELD_VAL_W-1:0] t;
    t = (VALUE_BITS+FIELD_VAL_W)'(v);
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic fval_t val_to_field(val_t v);
    logic [VALUE_BITS+FIELD_VAL_W-1:0] t;
    t = (VALUE_BITS+FIELD_VAL_W)'(v);
    return t[FIELD_VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/adll_dp.sv =====
// Datapath of the linked list engine: link, value and use memories, free head and result.
`default_nettype none
module adll_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire adll_pkg::dp_cmd_t cmd,
  output adll_pkg::dp_stat_t     stat,
  input  wire adll_pkg::mode_t   in_mode,
  input  wire adll_pkg::fidx_t   in_node_index,
  input  wire adll_pkg::fval_t   in_value,
  output adll_pkg::res_t         res
);
  import adll_pkg::*;

  val_t value_mem [SLOTS];
  idx_t next_mem  [SLOTS];
  idx_t prev_mem  [SLOTS];
  logic used_mem  [SLOTS];

  mode_t   mode_r;
  fidx_t   raw_r;
  fval_t   value_r;
  status_t status_r;
  idx_t    s_r;
  idx_t    after_r;
  idx_t    free_head_r, free_head_nxt;
  idx_t    head_r;
  idx_t    tail_r;
  idx_t    cnt_r;
  val_t    rd_val_r;
  idx_t    rd_next_r;
  idx_t    rd_prev_r;
  logic    rd_used_r;
  res_t    res_r, res_nxt;

  idx_t idx;
  logic idx_valid;
  idx_t rd_addr;
  idx_t clr_next;

  logic nx_we, pv_we, vl_we, us_we;
  idx_t nx_wa, nx_wd, pv_wa, pv_wd, vl_wa, us_wa;
  val_t vl_wd;
  logic us_wd;

  assign idx       = idx_of(raw_r);
  assign idx_valid = 32'(raw_r) < 32'(SLOTS);
  assign rd_addr   = cmd.rd_free ? free_head_r : idx;
  assign clr_next  = (cnt_r == IDX_W'(SLOTS - 1) || cnt_r == '0) ? '0 : cnt_r + IDX_W'(1);

  assign stat.idx_valid  = idx_valid;
  assign stat.idx_zero   = (idx == '0);
  assign stat.node_used  = rd_used_r;
  assign stat.free_empty = (free_head_r == '0);
  assign stat.clear_last = (cnt_r == IDX_W'(SLOTS - 1));

  always_comb begin
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    vl_we = 1'b0; vl_wa = '0; vl_wd = '0;
    us_we = 1'b0; us_wa = '0; us_wd = 1'b0;
    free_head_nxt = free_head_r;
    unique case (cmd.step)
      STEP_CLEAR: begin
        nx_we = 1'b1; nx_wa = cnt_r; nx_wd = clr_next;
        pv_we = 1'b1; pv_wa = cnt_r; pv_wd = '0;
        vl_we = 1'b1; vl_wa = cnt_r; vl_wd = '0;
        us_we = 1'b1; us_wa = cnt_r; us_wd = (cnt_r == '0);
      end
      STEP_PB_NODE: begin
        nx_we = 1'b1; nx_wa = s_r; nx_wd = '0;
        pv_we = 1'b1; pv_wa = s_r; pv_wd = tail_r;
        vl_we = 1'b1; vl_wa = s_r; vl_wd = val_of(value_r);
        us_we = 1'b1; us_wa = s_r; us_wd = 1'b1;
        free_head_nxt = rd_next_r;
      end
      STEP_PB_LINK: begin
        nx_we = 1'b1; nx_wa = tail_r; nx_wd = s_r;
        pv_we = 1'b1; pv_wa = '0;     pv_wd = s_r;
      end
      STEP_IA_NODE: begin
        nx_we = 1'b1; nx_wa = s_r; nx_wd = after_r;
        pv_we = 1'b1; pv_wa = s_r; pv_wd = idx;
        vl_we = 1'b1; vl_wa = s_r; vl_wd = val_of(value_r);
        us_we = 1'b1; us_wa = s_r; us_wd = 1'b1;
        free_head_nxt = rd_next_r;
      end
      STEP_IA_LINK: begin
        nx_we = 1'b1; nx_wa = idx;     nx_wd = s_r;
        pv_we = 1'b1; pv_wa = after_r; pv_wd = s_r;
      end
      STEP_ER_UNLINK: begin
        nx_we = 1'b1; nx_wa = rd_prev_r; nx_wd = rd_next_r;
        pv_we = 1'b1; pv_wa = rd_next_r; pv_wd = rd_prev_r;
      end
      STEP_ER_FREE: begin
        nx_we = 1'b1; nx_wa = idx; nx_wd = free_head_r;
        pv_we = 1'b1; pv_wa = idx; pv_wd = '0;
        us_we = 1'b1; us_wa = idx; us_wd = 1'b0;
        free_head_nxt = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (vl_we) value_mem[vl_wa] <= vl_wd;
    if (us_we) used_mem[us_wa] <= us_wd;
    rd_next_r <= next_mem[rd_addr];
    rd_prev_r <= prev_mem[rd_addr];
    rd_val_r  <= value_mem[rd_addr];
    rd_used_r <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      free_head_r <= IDX_W'(1);
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      if (cmd.step == STEP_CLEAR) cnt_r <= cnt_r + IDX_W'(1);
      free_head_r <= free_head_nxt;
      if (nx_we && nx_wa == '0) head_r <= nx_wd;
      if (pv_we && pv_wa == '0) tail_r <= pv_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      mode_r  <= in_mode;
      raw_r   <= in_node_index;
      value_r <= in_value;
    end
    if (cmd.cap) begin
      status_r <= ST_OK;
    end else if (cmd.status_we) begin
      status_r <= cmd.status_code;
    end
    if (cmd.step == STEP_TAKE) begin
      s_r     <= free_head_r;
      after_r <= rd_next_r;
    end
    if (cmd.load_out) res_r <= res_nxt;
  end

  always_comb begin
    logic ok;
    logic rd_ok;
    ok    = (status_r == ST_OK);
    rd_ok = (mode_r == MODE_READ) && idx_valid;
    res_nxt.status     = status_r;
    res_nxt.head_index = idx_to_field(head_r);
    res_nxt.tail_index = idx_to_field(tail_r);
    res_nxt.node_value = rd_ok ? val_to_field(rd_val_r) : '0;
    res_nxt.node_next  = rd_ok ? idx_to_field(rd_next_r) : '0;
    res_nxt.node_prev  = rd_ok ? idx_to_field(rd_prev_r) : '0;
    res_nxt.node_used  = rd_ok ? rd_used_r : 1'b0;
    unique case (mode_r)
      MODE_PUSH, MODE_INSERT: res_nxt.slot = ok ? idx_to_field(s_r) : '0;
      MODE_ERASE:             res_nxt.slot = ok ? idx_to_field(idx) : '0;
      default:                res_nxt.slot = idx_valid ? idx_to_field(idx) : '0;
    endcase
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/adll_ctrl.sv =====
// Controller state machine of the linked list engine: sequences each operation.
`default_nettype none
module adll_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire adll_pkg::mode_t    in_mode,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire adll_pkg::dp_stat_t stat,
  output adll_pkg::dp_cmd_t       cmd
);
  import adll_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PB_RD  = 4'd2;
  localparam logic [3:0] S_PB_W1  = 4'd3;
  localparam logic [3:0] S_PB_W2  = 4'd4;
  localparam logic [3:0] S_IA_RD  = 4'd5;
  localparam logic [3:0] S_IA_CHK = 4'd6;
  localparam logic [3:0] S_IA_W1  = 4'd7;
  localparam logic [3:0] S_IA_W2  = 4'd8;
  localparam logic [3:0] S_ER_RD  = 4'd9;
  localparam logic [3:0] S_ER_CHK = 4'd10;
  localparam logic [3:0] S_ER_W   = 4'd11;
  localparam logic [3:0] S_RD_RD  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.cap         = 1'b0;
    cmd.rd_free     = 1'b0;
    cmd.step        = STEP_NONE;
    cmd.status_we   = 1'b0;
    cmd.status_code = ST_OK;
    cmd.load_out    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.step = STEP_CLEAR;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap = 1'b1;
          unique case (in_mode)
            MODE_PUSH:   state_nxt = S_PB_RD;
            MODE_INSERT: state_nxt = S_IA_RD;
            MODE_ERASE:  state_nxt = S_ER_RD;
            default:     state_nxt = S_RD_RD;
          endcase
        end
      end
      S_PB_RD: begin
        if (stat.free_empty) begin
          cmd.status_we = 1'b1; cmd.status_code = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_free = 1'b1; cmd.step = STEP_TAKE;
          state_nxt = S_PB_W1;
        end
      end
      S_PB_W1: begin
        cmd.step = STEP_PB_NODE;
        state_nxt = S_PB_W2;
      end
      S_PB_W2: begin
        cmd.step = STEP_PB_LINK;
        state_nxt = S_DONE;
      end
      S_IA_RD: state_nxt = S_IA_CHK;
      S_IA_CHK: begin
        priority if (!stat.idx_valid || !stat.node_used) begin
          cmd.status_we = 1'b1; cmd.status_code = ST_FREE;
          state_nxt = S_DONE;
        end else if (stat.free_empty) begin
          cmd.status_we = 1'b1; cmd.status_code = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_free = 1'b1; cmd.step = STEP_TAKE;
          state_nxt = S_IA_W1;
        end
      end
      S_IA_W1: begin
        cmd.step = STEP_IA_NODE;
        state_nxt = S_IA_W2;
      end
      S_IA_W2: begin
        cmd.step = STEP_IA_LINK;
        state_nxt = S_DONE;
      end
      S_ER_RD: state_nxt = S_ER_CHK;
      S_ER_CHK: begin
        priority if (stat.idx_valid && stat.idx_zero) begin
          cmd.status_we = 1'b1; cmd.status_code = ST_SENTINEL;
          state_nxt = S_DONE;
        end else if (!stat.idx_valid || !stat.node_used) begin
          cmd.status_we = 1'b1; cmd.status_code = ST_FREE;
          state_nxt = S_DONE;
        end else begin
          cmd.step = STEP_ER_UNLINK;
          state_nxt = S_ER_W;
        end
      end
      S_ER_W: begin
        cmd.step = STEP_ER_FREE;
        state_nxt = S_DONE;
      end
      S_RD_RD: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_tready)       out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/array_doubly_linked_list_engine_top.sv =====
// Top level of the array based doubly linked list engine with free chain.
//
// channel  dir  tdata                                   tuser
// in_      in   node_index, value                       mode
// out_     out  status, slot, value, next, prev, used,  -
//               head_index, tail_index
//
// The engine works on one item at a time: in_tready is high only while it is idle. Each push,
// insert or erase reads, then writes its link entries in two write steps, since each memory
// has a single write port. After reset a clearing pass writes all SLOTS (64) entries to
// initialize the memories; in_tready stays low meanwhile. The result sits in an output
// register, so a stalled out_ side holds only the finishing step of the next item.
`default_nettype none
module array_doubly_linked_list_engine_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // node_index [5:0], value [37:6], zero [39:38]
  input  wire logic [adll_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode [1:0]
  input  wire logic [adll_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // status [1:0], slot [7:2], node_value [39:8], node_next [45:40], node_prev [51:46],
  // node_used [52], head_index [58:53], tail_index [64:59], zero [71:65]
  output logic [adll_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import adll_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;
  mode_t    mode;
  fidx_t    node_index;
  fval_t    value;

  assign mode       = in_tuser[MODE_W-1:0];
  assign node_index = in_tdata[FIELD_IDX_W-1:0];
  assign value      = in_tdata[FIELD_IDX_W+FIELD_VAL_W-1:FIELD_IDX_W];
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res};

  adll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (mode),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  adll_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (mode),
    .in_node_index (node_index),
    .in_value      (value),
    .res           (res)
  );

endmodule
`default_nettype wire

// ===== test/tb_array_doubly_linked_list_engine_top.sv =====
// Testbench for the array doubly linked list engine: stream stimulus, list predictor, checks.
`timescale 1ns / 1ps
module tb_array_doubly_linked_list_engine_top;
  import adll_pkg::*;

  class list_scoreboard;
    val_t    vals [SLOTS];
    fidx_t   nxt [SLOTS];
    fidx_t   prv [SLOTS];
    bit      used [SLOTS];
    fidx_t   free_head;
    int      count;
    res_t    pending [$];
    int      mismatches;
    int      checked;
    int      mode_seen [4];
    int      status_seen [4];
    int      times_full;
    int      times_empty;

    function void reset_state();
      for (int k = 0; k < SLOTS; k++) begin
        vals[k] = '0;
        prv[k]  = '0;
        used[k] = 1'b0;
        nxt[k]  = (k + 1 < SLOTS) ? fidx_t'(k + 1) : '0;
      end
      nxt[0]    = '0;
      used[0]   = 1'b1;
      free_head = fidx_t'(1);
      count     = 0;
    endfunction

    function fidx_t take_slot(fval_t value);
      fidx_t s;
      s         = free_head;
      free_head = nxt[s];
      vals[s]   = value;
      used[s]   = 1'b1;
      count++;
      if (count == SLOTS - 1) times_full++;
      return s;
    endfunction

    function void note_item(mode_t mode, fidx_t idx, fval_t value);
      res_t  r;
      fidx_t s;
      fidx_t a;
      fidx_t b;
      r = '0;
      r.status = ST_OK;
      case (mode)
        MODE_PUSH: begin
          if (free_head == 0) begin
            r.status = ST_FULL;
          end else begin
            a = prv[0];
            s = take_slot(value);
            nxt[s] = '0;
            prv[s] = a;
            nxt[a] = s;
            prv[0] = s;
            r.slot = s;
          end
        end
        MODE_INSERT: begin
          if (!used[idx]) begin
            r.status = ST_FREE;
          end else if (free_head == 0) begin
            r.status = ST_FULL;
          end else begin
            a = nxt[idx];
            s = take_slot(value);
            prv[a]   = s;
            nxt[s]   = a;
            prv[s]   = idx;
            nxt[idx] = s;
            r.slot   = s;
          end
        end
        MODE_ERASE: begin
          if (idx == 0) begin
            r.status = ST_SENTINEL;
          end else if (!used[idx]) begin
            r.status = ST_FREE;
          end else begin
            a = nxt[idx];
            b = prv[idx];
            prv[a]    = b;
            nxt[b]    = a;
            used[idx] = 1'b0;
            prv[idx]  = '0;
            nxt[idx]  = free_head;
            free_head = idx;
            r.slot    = idx;
            count--;
            if (count == 0) times_empty++;
          end
        end
        default: begin
          r.node_value = vals[idx];
          r.node_next  = nxt[idx];
          r.node_prev  = prv[idx];
          r.node_used  = used[idx];
          r.slot       = idx;
        end
      endcase
      r.head_index = nxt[0];
      r.tail_index = prv[0];
      mode_seen[mode]++;
      status_seen[r.status]++;
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending: %h", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.status !== want.status || got.slot !== want.slot ||
          got.node_value !== want.node_value || got.node_next !== want.node_next ||
          got.node_prev !== want.node_prev || got.node_used !== want.node_used ||
          got.head_index !== want.head_index || got.tail_index !== want.tail_index) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("mismatch (expected/actual): status %0d/%0d slot %0d/%0d value %h/%h ",
                 want.status, got.status, want.slot, got.slot,
                 want.node_value, got.node_value);
          $display("next %0d/%0d prev %0d/%0d used %0d/%0d head %0d/%0d tail %0d/%0d",
                   want.node_next, got.node_next, want.node_prev, got.node_prev,
                   want.node_used, got.node_used, want.head_index, got.head_index,
                   want.tail_index, got.tail_index);
        end
      end
    endfunction
  endclass

  typedef enum {PH_GROW, PH_FULL, PH_SHRINK} phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  list_scoreboard sb;
  bit             hold_req;
  bit             holding;
  int             burst;
  phase_t         phase;
  int             dwell;

  array_doubly_linked_list_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic fidx_t pick_slot(bit with_sentinel);
    fidx_t cand [$];
    for (int k = with_sentinel ? 0 : 1; k < SLOTS; k++)
      if (sb.used[k]) cand.push_back(fidx_t'(k));
    if (cand.size() == 0) return fidx_t'($urandom_range(0, SLOTS - 1));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  task automatic run_item(mode_t mode, fidx_t idx, fval_t value);
    int n;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, value, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, idx, value);
    if (burst > 0) burst--;
    else if ($urandom_range(0, 99) == 0) burst = 40;
    n = (holding || burst > 0 || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_item();
    mode_t m;
    fidx_t idx;
    fval_t v;
    int    r;
    if (phase == PH_GROW && sb.count == SLOTS - 1) begin
      phase = PH_FULL;
      dwell = $urandom_range(3, 8);
    end
    if (phase == PH_FULL && dwell == 0) phase = PH_SHRINK;
    if (phase == PH_SHRINK && sb.count == 0) phase = PH_GROW;
    r = $urandom_range(0, 99);
    case (phase)
      PH_GROW:   m = r < 40 ? MODE_PUSH : r < 75 ? MODE_INSERT : r < 85 ? MODE_ERASE : MODE_READ;
      PH_FULL:   m = r < 40 ? MODE_PUSH : r < 80 ? MODE_INSERT : MODE_READ;
      default:   m = r < 15 ? MODE_PUSH : r < 25 ? MODE_INSERT : r < 85 ? MODE_ERASE : MODE_READ;
    endcase
    if (phase == PH_FULL) dwell--;
    if ($urandom_range(0, 3) != 0) idx = pick_slot(m != MODE_ERASE);
    else idx = fidx_t'($urandom_range(0, SLOTS - 1));
    v = $urandom;
    case ($urandom_range(0, 19))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3: v = 32'h0000_0000;
      default: ;
    endcase
    run_item(m, idx, v);
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        holding = 1'b0;
      end else if ($urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
        repeat (($urandom_range(0, 19) == 0) ? 100 : $urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(res_t'(out_tdata[RES_W-1:0]));
  end

  initial begin
    sb = new;
    sb.reset_state();
    hold_req  = 1'b0;
    holding   = 1'b0;
    burst     = 0;
    phase     = PH_GROW;
    dwell     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_PUSH;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_item(MODE_READ,   6'd0,  32'h0);
    run_item(MODE_READ,   6'd63, 32'h0);
    run_item(MODE_READ,   6'd5,  32'hffff_ffff);
    run_item(MODE_ERASE,  6'd0,  32'h0);
    run_item(MODE_ERASE,  6'd7,  32'h0);
    run_item(MODE_INSERT, 6'd9,  32'h1234_5678);
    run_item(MODE_PUSH,   6'd0,  32'h7fff_ffff);
    run_item(MODE_PUSH,   6'd63, 32'h8000_0000);
    run_item(MODE_PUSH,   6'd0,  32'h0000_0000);
    run_item(MODE_PUSH,   6'd21, 32'hffff_ffff);
    run_item(MODE_INSERT, 6'd0,  32'h5555_5555);
    run_item(MODE_INSERT, 6'd4,  32'haaaa_aaaa);
    run_item(MODE_INSERT, 6'd2,  32'h0f0f_f0f0);
    run_item(MODE_READ,   6'd5,  32'h0);
    run_item(MODE_READ,   6'd6,  32'h0);
    run_item(MODE_READ,   6'd2,  32'h0);
    run_item(MODE_ERASE,  6'd5,  32'h0);
    run_item(MODE_ERASE,  6'd6,  32'h0);
    run_item(MODE_ERASE,  6'd2,  32'h0);
    run_item(MODE_ERASE,  6'd2,  32'h0);
    run_item(MODE_READ,   6'd2,  32'h0);
    run_item(MODE_ERASE,  6'd63, 32'h0);
    run_item(MODE_INSERT, 6'd63, 32'hdead_beef);
    run_item(MODE_PUSH,   6'd42, 32'h0000_0001);
    run_item(MODE_READ,   6'd0,  32'h0);

    for (int i = 0; i < 1100; i++) begin
      if (i == 400) hold_req = 1'b1;
      random_item();
    end
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("items: push %0d, insert %0d, erase %0d, read %0d; results checked %0d",
             sb.mode_seen[MODE_PUSH], sb.mode_seen[MODE_INSERT],
             sb.mode_seen[MODE_ERASE], sb.mode_seen[MODE_READ], sb.checked);
    $display("status ok %0d, free %0d, full %0d, sentinel %0d; filled %0d, emptied %0d times",
             sb.status_seen[ST_OK], sb.status_seen[ST_FREE], sb.status_seen[ST_FULL],
             sb.status_seen[ST_SENTINEL], sb.times_full, sb.times_empty);
    if (sb.mismatches == 0) begin
      $display("tb_array_doubly_linked_list_engine_top OK");
    end else begin
      $display("mismatches: %0d", sb.mismatches);
      $display("tb_array_doubly_linked_list_engine_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("tb_array_doubly_linked_list_engine_top NOT OK");
    $finish;
  end

endmodule

// ===== array_doubly_linked_list_engine_top.f =====
rtl/adll_pkg.sv
rtl/adll_dp.sv
rtl/adll_ctrl.sv
rtl/array_doubly_linked_list_engine_top.sv
test/tb_array_doubly_linked_list_engine_top.sv
